FILE: sv/its_pkg.sv
// ----------------------------------------------------------------------------
// its_pkg
// Shared constants, codes and controller/datapath types of the interval task
// scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package its_pkg;

  localparam int unsigned SLOTS   = 8;
  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned COUNT_W = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_TICK   = 2'd2,
    FN_SORT   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KD_ADD_ACK    = 3'd0,
    KD_REMOVE_ACK = 3'd1,
    KD_DUE        = 3'd2,
    KD_NONE_DUE   = 3'd3,
    KD_SORT_DONE  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    SC_OK        = 2'd0,
    SC_FULL      = 2'd1,
    SC_NOT_FOUND = 2'd2,
    SC_ZERO_ID   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_STEP,
    OP_ADD,
    OP_REMOVE,
    OP_FIRE,
    OP_SORT,
    OP_FINAL
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    func_e func;
    logic  id_zero;
    logic  hit;
    logic  at_end;
    logic  pend;
    logic  out_free;
  } dp_sts_t;

  // Low three bits of a slot index, as the result field carries it.
  function automatic logic [2:0] slot_field(logic [SLOT_W-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[2:0];
  endfunction

  // Low four bits of the free slot count.
  function automatic logic [3:0] free_field(logic [COUNT_W-1:0] used);
    logic [31:0] w;
    w = 32'(SLOTS) - 32'(used);
    return w[3:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/its_if.sv
// ----------------------------------------------------------------------------
// its_if
// Valid/ready channels of the interval task scheduler: operation items in,
// result items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface its_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] task_id;
  logic [31:0] interval;
  logic [31:0] now;

  modport source (output valid, output func, output task_id, output interval,
                  output now, input ready);
  modport sink   (input valid, input func, input task_id, input interval,
                  input now, output ready);
endinterface

interface its_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  status;
  logic [15:0] due_task;
  logic [2:0]  slot;
  logic [3:0]  free_slots;
  logic        last;

  modport source (output valid, output kind, output status, output due_task,
                  output slot, output free_slots, output last, input ready);
  modport sink   (input valid, input kind, input status, input due_task,
                  input slot, input free_slots, input last, output ready);
endinterface

`default_nettype wire

FILE: sv/interval_task_scheduler.sv
// ----------------------------------------------------------------------------
// interval_task_scheduler
// Periodic task table with add, remove, tick and sort-by-interval operations.
// ----------------------------------------------------------------------------
// One item is worked at a time. The sequencer visits one slot per cycle while
// no tick is held; an add or remove ends early on a zero id or a hit, else
// after a full scan, and a sort runs SLOTS odd-even compare passes over the
// table. A tick that finds several due tasks waits in place whenever the
// single output register has not been drained, so a slow sink holds the scan.
// Results leave through an output register, and the next item is accepted
// while the last result of the previous one is still waiting there.
`default_nettype none

module interval_task_scheduler (
  input  logic clk_i,
  input  logic rst_ni,
  its_in_if.sink    in_i,
  its_out_if.source out_o
);

  its_pkg::dp_cmd_t cmd;
  its_pkg::dp_sts_t sts;

  its_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  its_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_func_i        (in_i.func),
    .in_task_id_i     (in_i.task_id),
    .in_interval_i    (in_i.interval),
    .in_now_i         (in_i.now),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .out_kind_o       (out_o.kind),
    .out_status_o     (out_o.status),
    .out_due_task_o   (out_o.due_task),
    .out_slot_o       (out_o.slot),
    .out_free_slots_o (out_o.free_slots),
    .out_last_o       (out_o.last)
  );

endmodule

`default_nettype wire

FILE: sv/its_ctrl.sv
// ----------------------------------------------------------------------------
// its_ctrl
// Sequencer: accepts one item, walks the slot table one slot per cycle while no
// tick waits on the output register, and hands the final result to that register.
// ----------------------------------------------------------------------------
`default_nettype none

module its_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  its_pkg::dp_sts_t sts_i,
  output its_pkg::dp_cmd_t cmd_o
);

  its_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= its_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      its_pkg::S_IDLE: begin
        if (in_valid_i) state_d = its_pkg::S_SCAN;
      end
      its_pkg::S_SCAN: begin
        unique case (sts_i.func)
          its_pkg::FN_ADD, its_pkg::FN_REMOVE: begin
            if (sts_i.id_zero || sts_i.hit || sts_i.at_end) state_d = its_pkg::S_FINISH;
          end
          its_pkg::FN_TICK: begin
            // hold while a due task waits behind a full output register
            if (sts_i.at_end && !(sts_i.hit && sts_i.pend && !sts_i.out_free)) begin
              state_d = its_pkg::S_FINISH;
            end
          end
          its_pkg::FN_SORT: begin
            if (sts_i.at_end) state_d = its_pkg::S_FINISH;
          end
        endcase
      end
      its_pkg::S_FINISH: begin
        if (sts_i.out_free) state_d = its_pkg::S_IDLE;
      end
      default: state_d = its_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = its_pkg::OP_NONE;
    unique case (state_q)
      its_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = its_pkg::OP_LOAD;
      end
      its_pkg::S_SCAN: begin
        unique case (sts_i.func)
          its_pkg::FN_ADD: begin
            if (!sts_i.id_zero) cmd_o.op = sts_i.hit ? its_pkg::OP_ADD : its_pkg::OP_STEP;
          end
          its_pkg::FN_REMOVE: begin
            if (!sts_i.id_zero) cmd_o.op = sts_i.hit ? its_pkg::OP_REMOVE : its_pkg::OP_STEP;
          end
          its_pkg::FN_TICK: begin
            if (!sts_i.hit) begin
              cmd_o.op = its_pkg::OP_STEP;
            end else if (!sts_i.pend || sts_i.out_free) begin
              cmd_o.op = its_pkg::OP_FIRE;
            end
          end
          its_pkg::FN_SORT: cmd_o.op = its_pkg::OP_SORT;
        endcase
      end
      its_pkg::S_FINISH: begin
        if (sts_i.out_free) cmd_o.op = its_pkg::OP_FINAL;
      end
      default: cmd_o.op = its_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/its_dp.sv
// ----------------------------------------------------------------------------
// its_dp
// Datapath: slot table, scan index, due check, odd-even sort network, the
// pending due task and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module its_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  its_pkg::dp_cmd_t        cmd_i,
  output its_pkg::dp_sts_t        sts_o,
  input  logic [1:0]              in_func_i,
  input  logic [15:0]             in_task_id_i,
  input  logic [31:0]             in_interval_i,
  input  logic [31:0]             in_now_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [2:0]              out_kind_o,
  output logic [1:0]              out_status_o,
  output logic [15:0]             out_due_task_o,
  output logic [2:0]              out_slot_o,
  output logic [3:0]              out_free_slots_o,
  output logic                    out_last_o
);

  localparam int unsigned SW = its_pkg::SLOT_W;
  localparam int unsigned CW = its_pkg::COUNT_W;
  localparam int unsigned N  = its_pkg::SLOTS;

  // latched item
  its_pkg::func_e func_q;
  logic [15:0]    id_q;
  logic [31:0]    ivl_in_q;
  logic [31:0]    now_q;

  // slot table
  logic [15:0]    task_q [N];
  logic [31:0]    ivl_q  [N];
  logic [31:0]    lf_q   [N];
  logic [15:0]    task_d [N];
  logic [31:0]    ivl_d  [N];
  logic [31:0]    lf_d   [N];
  logic [CW-1:0]  used_q, used_d;

  // scan state
  logic [SW-1:0]  idx_q, idx_next;
  logic           found_q;
  logic [SW-1:0]  found_idx_q;
  logic           pend_q;
  logic [15:0]    pend_task_q;
  logic [SW-1:0]  pend_idx_q;

  // output register
  logic           ovalid_q;
  its_pkg::kind_e okind_q;
  its_pkg::status_e ostatus_q;
  logic [15:0]    otask_q;
  logic [2:0]     oslot_q;
  logic [3:0]     ofree_q;
  logic           olast_q;

  logic [15:0]    cur_task;
  logic [31:0]    cur_ivl;
  logic [31:0]    cur_lf;
  logic [31:0]    age;
  logic           hit;
  logic           at_end;
  logic           out_free;
  logic           push;
  logic [N-2:0]   swap;

  its_pkg::kind_e   fin_kind;
  its_pkg::status_e fin_status;
  logic [15:0]      fin_task;
  logic [2:0]       fin_slot;

  assign cur_task = task_q[idx_q];
  assign cur_ivl  = ivl_q[idx_q];
  assign cur_lf   = lf_q[idx_q];
  assign age      = now_q - cur_lf;
  assign at_end   = (idx_q == SW'(N - 1));
  assign idx_next = at_end ? '0 : idx_q + SW'(1);
  assign out_free = !ovalid_q || out_ready_i;
  assign push     = (cmd_i.op == its_pkg::OP_FINAL) || ((cmd_i.op == its_pkg::OP_FIRE) && pend_q);

  always_comb begin
    unique case (func_q)
      its_pkg::FN_ADD:    hit = (cur_task == '0);
      its_pkg::FN_REMOVE: hit = (cur_task == id_q);
      its_pkg::FN_TICK:   hit = (cur_task != '0) && (age >= cur_ivl);
      its_pkg::FN_SORT:   hit = 1'b0;
      default:            hit = 1'b0;
    endcase
  end

  assign sts_o.func     = func_q;
  assign sts_o.id_zero  = (id_q == '0);
  assign sts_o.hit      = hit;
  assign sts_o.at_end   = at_end;
  assign sts_o.pend     = pend_q;
  assign sts_o.out_free = out_free;

  // Compare-exchange of neighbors; even pairs on even passes, odd on odd.
  // An empty slot ranks above every task, equal intervals never swap.
  always_comb begin
    for (int k = 0; k < N - 1; k++) begin
      swap[k] = (1'(k) == idx_q[0]) && (task_q[k+1] != '0) &&
                ((task_q[k] == '0) || (ivl_q[k] > ivl_q[k+1]));
    end
  end

  always_comb begin
    task_d = task_q;
    ivl_d  = ivl_q;
    lf_d   = lf_q;
    used_d = used_q;
    unique case (cmd_i.op)
      its_pkg::OP_ADD: begin
        task_d[idx_q] = id_q;
        ivl_d[idx_q]  = ivl_in_q;
        lf_d[idx_q]   = now_q;
        used_d        = used_q + CW'(1);
      end
      its_pkg::OP_REMOVE: begin
        task_d[idx_q] = '0;
        ivl_d[idx_q]  = '0;
        lf_d[idx_q]   = '0;
        if (used_q != '0) used_d = used_q - CW'(1);
      end
      its_pkg::OP_FIRE: begin
        lf_d[idx_q] = now_q;
      end
      its_pkg::OP_SORT: begin
        for (int k = 0; k < N - 1; k++) begin
          if (swap[k]) begin
            task_d[k]   = task_q[k+1];
            task_d[k+1] = task_q[k];
            ivl_d[k]    = ivl_q[k+1];
            ivl_d[k+1]  = ivl_q[k];
            lf_d[k]     = lf_q[k+1];
            lf_d[k+1]   = lf_q[k];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) begin
        task_q[k] <= '0;
        ivl_q[k]  <= '0;
        lf_q[k]   <= '0;
      end
      used_q <= '0;
    end else begin
      task_q <= task_d;
      ivl_q  <= ivl_d;
      lf_q   <= lf_d;
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      found_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        its_pkg::OP_LOAD: begin
          idx_q   <= '0;
          found_q <= 1'b0;
          pend_q  <= 1'b0;
        end
        its_pkg::OP_STEP, its_pkg::OP_SORT: idx_q <= idx_next;
        its_pkg::OP_ADD, its_pkg::OP_REMOVE: found_q <= 1'b1;
        its_pkg::OP_FIRE: begin
          idx_q  <= idx_next;
          pend_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == its_pkg::OP_LOAD) begin
      func_q   <= its_pkg::func_e'(in_func_i);
      id_q     <= in_task_id_i;
      ivl_in_q <= in_interval_i;
      now_q    <= in_now_i;
    end
    if ((cmd_i.op == its_pkg::OP_ADD) || (cmd_i.op == its_pkg::OP_REMOVE)) begin
      found_idx_q <= idx_q;
    end
    if (cmd_i.op == its_pkg::OP_FIRE) begin
      pend_task_q <= cur_task;
      pend_idx_q  <= idx_q;
    end
  end

  always_comb begin
    fin_kind   = its_pkg::KD_SORT_DONE;
    fin_status = its_pkg::SC_OK;
    fin_task   = '0;
    fin_slot   = '0;
    unique case (func_q)
      its_pkg::FN_ADD, its_pkg::FN_REMOVE: begin
        fin_kind = (func_q == its_pkg::FN_ADD) ? its_pkg::KD_ADD_ACK : its_pkg::KD_REMOVE_ACK;
        fin_task = id_q;
        priority if (id_q == '0) begin
          fin_status = its_pkg::SC_ZERO_ID;
        end else if (found_q) begin
          fin_slot = its_pkg::slot_field(found_idx_q);
        end else begin
          fin_status = (func_q == its_pkg::FN_ADD) ? its_pkg::SC_FULL : its_pkg::SC_NOT_FOUND;
        end
      end
      its_pkg::FN_TICK: begin
        if (pend_q) begin
          fin_kind = its_pkg::KD_DUE;
          fin_task = pend_task_q;
          fin_slot = its_pkg::slot_field(pend_idx_q);
        end else begin
          fin_kind = its_pkg::KD_NONE_DUE;
        end
      end
      its_pkg::FN_SORT: fin_kind = its_pkg::KD_SORT_DONE;
      default: fin_kind = its_pkg::KD_SORT_DONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (push) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ofree_q <= its_pkg::free_field(used_q);
      if (cmd_i.op == its_pkg::OP_FINAL) begin
        okind_q   <= fin_kind;
        ostatus_q <= fin_status;
        otask_q   <= fin_task;
        oslot_q   <= fin_slot;
        olast_q   <= 1'b1;
      end else begin
        // a newer due task was found: release the held one as non-final
        okind_q   <= its_pkg::KD_DUE;
        ostatus_q <= its_pkg::SC_OK;
        otask_q   <= pend_task_q;
        oslot_q   <= its_pkg::slot_field(pend_idx_q);
        olast_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o      = ovalid_q;
  assign out_kind_o       = okind_q;
  assign out_status_o     = ostatus_q;
  assign out_due_task_o   = otask_q;
  assign out_slot_o       = oslot_q;
  assign out_free_slots_o = ofree_q;
  assign out_last_o       = olast_q;

endmodule

`default_nettype wire

FILE: sv/its_checker.sv
// ----------------------------------------------------------------------------
// its_checker
// Port-level checks of the interval task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module its_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_kind_i,
  input logic [1:0]  out_status_i,
  input logic [15:0] out_due_task_i,
  input logic [2:0]  out_slot_i,
  input logic        out_last_i
);

  // a pending result stays until the transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  // only due tasks may be followed by more results of the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> out_kind_i == its_pkg::KD_DUE)
    else $error("non-final result that is not a due task");

  // tick-none and sort-done carry no task, no slot and status ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == its_pkg::KD_NONE_DUE || out_kind_i == its_pkg::KD_SORT_DONE)
    |-> out_status_i == its_pkg::SC_OK && out_due_task_i == '0 && out_slot_i == '0)
    else $error("empty result carries payload");

  // a zero-id rejection belongs to add or remove only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == its_pkg::SC_ZERO_ID
    |-> (out_kind_i == its_pkg::KD_ADD_ACK || out_kind_i == its_pkg::KD_REMOVE_ACK)
        && out_due_task_i == '0)
    else $error("zero-id status on wrong result");

endmodule

bind interval_task_scheduler its_checker u_its_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_kind_i     (out_o.kind),
  .out_status_i   (out_o.status),
  .out_due_task_i (out_o.due_task),
  .out_slot_i     (out_o.slot),
  .out_last_i     (out_o.last)
);

`default_nettype wire
